@@ rtl/core/mslddf_pkg.sv @@
`default_nettype none

package mslddf_pkg;

  localparam int SLOTS        = 8;
  localparam int USABLE_SLOTS = (SLOTS < 8) ? SLOTS : 8;
  localparam int IDX_W        = (USABLE_SLOTS > 1) ? $clog2(USABLE_SLOTS) : 1;

  localparam logic [3:0] USABLE_SLOTS_N    = 4'(USABLE_SLOTS);
  localparam logic [7:0] LENGTH_POS        = 8'd4;
  localparam logic [7:0] MIN_FRAME_LEN_RST = 8'd8;
  localparam logic [7:0] MAX_FRAME_LEN_RST = 8'd80;

  localparam logic [1:0] REQ_DATA       = 2'd0;
  localparam logic [1:0] REQ_CONNECT    = 2'd1;
  localparam logic [1:0] REQ_DISCONNECT = 2'd2;

  localparam logic CFG_MIN_FRAME_LEN = 1'b0;
  localparam logic CFG_MAX_FRAME_LEN = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] slot;
    logic [7:0] data_byte;
    logic       chunk_end;
  } in_t;

  typedef struct packed {
    logic [2:0] out_slot;
    logic       no_free_slot;
    logic [7:0] out_byte;
    logic [7:0] byte_position;
    logic       frame_last;
    logic       malformed;
    logic       dropped;
  } out_t;

  typedef struct packed {
    logic [7:0] pos;
    logic [7:0] exp_len;
    logic       skip;
  } parse_row_t;

  typedef struct packed {
    logic       open;
    parse_row_t row;
    logic       free_found;
    idx_t       free_idx;
  } tbl_status_t;

  typedef struct packed {
    logic       open_set;
    logic       open_clr;
    logic       row_wr;
    idx_t       idx;
    parse_row_t row;
  } tbl_update_t;

endpackage

`default_nettype wire

@@ rtl/core/mslddf_slot_table.sv @@
`default_nettype none

module mslddf_slot_table (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire mslddf_pkg::idx_t         rd_idx_i,
  input  wire mslddf_pkg::tbl_update_t  upd_i,
  output mslddf_pkg::tbl_status_t       stat_o
);

  logic [mslddf_pkg::USABLE_SLOTS-1:0] open_q;
  mslddf_pkg::parse_row_t              row_q [mslddf_pkg::USABLE_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
      for (int k = 0; k < mslddf_pkg::USABLE_SLOTS; k++) begin
        row_q[k].pos     <= '0;
        row_q[k].exp_len <= mslddf_pkg::MIN_FRAME_LEN_RST;
        row_q[k].skip    <= 1'b0;
      end
    end else begin
      if (upd_i.open_set) begin
        open_q[upd_i.idx] <= 1'b1;
      end
      if (upd_i.open_clr) begin
        open_q[upd_i.idx] <= 1'b0;
      end
      if (upd_i.row_wr) begin
        row_q[upd_i.idx] <= upd_i.row;
      end
    end
  end

  // lowest closed slot
  always_comb begin
    stat_o.open       = open_q[rd_idx_i];
    stat_o.row        = row_q[rd_idx_i];
    stat_o.free_found = 1'b0;
    stat_o.free_idx   = '0;
    for (int k = mslddf_pkg::USABLE_SLOTS - 1; k >= 0; k--) begin
      if (!open_q[k]) begin
        stat_o.free_found = 1'b1;
        stat_o.free_idx   = mslddf_pkg::IDX_W'(k);
      end
    end
  end

  a_set_clr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(upd_i.open_set && upd_i.open_clr))
    else $error("slot opened and closed in the same transaction");

  a_open_only_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i.open_set |-> !open_q[upd_i.idx])
    else $error("connect took a slot that is already open");

  a_open_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i.open_set |=> open_q[$past(upd_i.idx)])
    else $error("connected slot not marked open");

endmodule

`default_nettype wire

@@ rtl/core/mslddf_parse.sv @@
`default_nettype none

module mslddf_parse (
  input  wire mslddf_pkg::in_t          item_i,
  input  wire mslddf_pkg::tbl_status_t  stat_i,
  input  wire logic [7:0]               min_len_i,
  input  wire logic [7:0]               max_len_i,
  output mslddf_pkg::out_t              res_o,
  output mslddf_pkg::tbl_update_t       upd_o
);

  logic       in_range;
  logic       at_len;
  logic       len_bad;
  logic [7:0] next_pos;
  logic [7:0] exp_eff;

  assign in_range = {1'b0, item_i.slot} < mslddf_pkg::USABLE_SLOTS_N;
  assign at_len   = stat_i.row.pos == mslddf_pkg::LENGTH_POS;
  assign len_bad  = (item_i.data_byte < min_len_i) || (item_i.data_byte > max_len_i);
  assign next_pos = stat_i.row.pos + 8'd1;
  assign exp_eff  = at_len ? item_i.data_byte : stat_i.row.exp_len;

  always_comb begin
    res_o          = '0;
    res_o.out_slot = item_i.slot;
    upd_o          = '0;
    upd_o.idx      = item_i.slot[mslddf_pkg::IDX_W-1:0];
    upd_o.row      = stat_i.row;
    case (item_i.req_type)
      mslddf_pkg::REQ_CONNECT: begin
        if (stat_i.free_found) begin
          upd_o.open_set = 1'b1;
          upd_o.idx      = stat_i.free_idx;
          res_o.out_slot = 3'(stat_i.free_idx);
        end else begin
          res_o.out_slot     = '0;
          res_o.no_free_slot = 1'b1;
        end
      end
      mslddf_pkg::REQ_DISCONNECT: begin
        if (in_range) begin
          upd_o.open_clr    = 1'b1;
          upd_o.row_wr      = 1'b1;
          upd_o.row.pos     = '0;
          upd_o.row.exp_len = min_len_i;
          upd_o.row.skip    = 1'b0;
        end
      end
      mslddf_pkg::REQ_DATA: begin
        res_o.out_byte = item_i.data_byte;
        if (!in_range || !stat_i.open) begin
          res_o.dropped = 1'b1;
        end else if (stat_i.row.skip) begin
          res_o.dropped = 1'b1;
          if (item_i.chunk_end) begin
            upd_o.row_wr   = 1'b1;
            upd_o.row.skip = 1'b0;
          end
        end else begin
          res_o.byte_position = stat_i.row.pos;
          upd_o.row_wr        = 1'b1;
          if (at_len && len_bad) begin
            res_o.malformed   = 1'b1;
            upd_o.row.pos     = '0;
            upd_o.row.exp_len = min_len_i;
            upd_o.row.skip    = !item_i.chunk_end;
          end else if (next_pos == exp_eff) begin
            res_o.frame_last  = 1'b1;
            upd_o.row.pos     = '0;
            upd_o.row.exp_len = min_len_i;
          end else begin
            upd_o.row.pos     = next_pos;
            upd_o.row.exp_len = exp_eff;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/multi_slot_length_deframer_top.sv @@
// Multi-slot length-prefixed frame deframer.
// Input channel (in_valid_i / in_stall_o / in_i) carries one request per
// transaction: a data byte for a slot, a connect or a disconnect event.
// Output channel (out_valid_o / out_stall_i / out_o) returns exactly one
// result per request, in order: assigned slot, pass-through byte with its
// frame position, frame-complete, malformed-length and dropped flags.
// Configuration channel (cfg_valid_i / cfg_ready_o) writes the minimum
// (index 0) and maximum (index 1) frame length; write it only while idle.
// A request is held in the input register and its result in the result
// register, which drives the output. Throughput: one request per cycle
// unless the output stalls; the per-slot table update is a single
// read-modify-write between the input register and the result register.
// Reset: all slots closed, parse state cleared, lengths 8 and 80.
// While out_stall_i holds, the result register holds; one more request
// sits in the input register, after which in_stall_o rises.
`default_nettype none

module multi_slot_length_deframer_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire mslddf_pkg::in_t   in_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output mslddf_pkg::out_t       out_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              cfg_index_i,
  input  wire logic [7:0]        cfg_data_i
);

  logic                    s1_valid_q, s1_valid_d;
  mslddf_pkg::in_t         s1_item_q;
  logic                    s2_valid_q, s2_valid_d;
  mslddf_pkg::out_t        s2_res_q;
  logic [7:0]              min_len_q;
  logic [7:0]              max_len_q;
  logic                    s2_ready;
  logic                    advance;
  logic                    accept;
  mslddf_pkg::out_t        res;
  mslddf_pkg::tbl_update_t upd_raw;
  mslddf_pkg::tbl_update_t upd;
  mslddf_pkg::tbl_status_t stat;

  assign s2_ready    = !s2_valid_q || !out_stall_i;
  assign advance     = s1_valid_q && s2_ready;
  assign in_stall_o  = s1_valid_q && !s2_ready;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = s2_valid_q;
  assign out_o       = s2_res_q;

  assign s1_valid_d = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign s2_valid_d = s2_ready ? advance : s2_valid_q;

  always_comb begin
    upd          = upd_raw;
    upd.open_set = upd_raw.open_set && advance;
    upd.open_clr = upd_raw.open_clr && advance;
    upd.row_wr   = upd_raw.row_wr && advance;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      min_len_q  <= mslddf_pkg::MIN_FRAME_LEN_RST;
      max_len_q  <= mslddf_pkg::MAX_FRAME_LEN_RST;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          mslddf_pkg::CFG_MIN_FRAME_LEN: min_len_q <= cfg_data_i;
          mslddf_pkg::CFG_MAX_FRAME_LEN: max_len_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_i;
    end
    if (advance) begin
      s2_res_q <= res;
    end
  end

  mslddf_slot_table u_slot_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (s1_item_q.slot[mslddf_pkg::IDX_W-1:0]),
    .upd_i    (upd),
    .stat_o   (stat)
  );

  mslddf_parse u_parse (
    .item_i    (s1_item_q),
    .stat_i    (stat),
    .min_len_i (min_len_q),
    .max_len_i (max_len_q),
    .res_o     (res),
    .upd_o     (upd_raw)
  );

  a_no_free_slot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.no_free_slot) |-> (out_o.out_slot == '0))
    else $error("no free slot reported with nonzero slot");

  a_malformed_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.malformed) |-> (!out_o.frame_last && !out_o.dropped))
    else $error("malformed result also flagged last or dropped");

  a_dropped_pos0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.dropped) |-> (out_o.byte_position == '0 && !out_o.frame_last))
    else $error("dropped byte carries a frame position");

  a_table_write_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd.open_set || upd.open_clr || upd.row_wr) |=> s2_valid_q)
    else $error("slot table written without producing a result");

endmodule

`default_nettype wire

@@ bench/tb_multi_slot_length_deframer_top.sv @@
`timescale 1ns / 1ps

module tb_multi_slot_length_deframer_top;
  import mslddf_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int LONG_HOLD       = 150;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t want;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_t        in_i        = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_t       out_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_index_i = 1'b0;
  logic [7:0] cfg_data_i  = '0;

  logic [7:0] lim_min = MIN_FRAME_LEN_RST;
  logic [7:0] lim_max = MAX_FRAME_LEN_RST;
  logic       slot_on    [8];
  logic [7:0] frame_pos  [8];
  logic [7:0] frame_len  [8];
  logic       skip_chunk [8];

  out_t pending_results[$];
  int   mismatches  = 0;
  int   cycle_count = 0;
  bit   tx_idle_en  = 1'b0;
  bit   rx_idle_en  = 1'b0;
  bit   rx_hold_req = 1'b0;

  multi_slot_length_deframer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_t predict_deframe(in_t req);
    out_t       r;
    logic       found;
    logic [7:0] nxt;
    r          = '0;
    r.out_slot = req.slot;
    found      = 1'b0;
    case (req.req_type)
      REQ_CONNECT: begin
        for (int k = 0; k < USABLE_SLOTS; k++) begin
          if (!found && !slot_on[k]) begin
            slot_on[k] = 1'b1;
            r.out_slot = 3'(k);
            found      = 1'b1;
          end
        end
        if (!found) begin
          r.out_slot     = '0;
          r.no_free_slot = 1'b1;
        end
      end
      REQ_DISCONNECT: begin
        if (req.slot < USABLE_SLOTS) begin
          slot_on[req.slot]    = 1'b0;
          frame_pos[req.slot]  = '0;
          frame_len[req.slot]  = lim_min;
          skip_chunk[req.slot] = 1'b0;
        end
      end
      REQ_DATA: begin
        r.out_byte = req.data_byte;
        if (req.slot >= USABLE_SLOTS || !slot_on[req.slot]) begin
          r.dropped = 1'b1;
        end else if (skip_chunk[req.slot]) begin
          if (req.chunk_end) skip_chunk[req.slot] = 1'b0;
          r.dropped = 1'b1;
        end else begin
          r.byte_position = frame_pos[req.slot];
          if (frame_pos[req.slot] == LENGTH_POS) begin
            if (req.data_byte < lim_min || req.data_byte > lim_max) begin
              r.malformed          = 1'b1;
              frame_pos[req.slot]  = '0;
              frame_len[req.slot]  = lim_min;
              skip_chunk[req.slot] = !req.chunk_end;
            end else begin
              frame_len[req.slot] = req.data_byte;
            end
          end
          if (!r.malformed) begin
            nxt = frame_pos[req.slot] + 8'd1;
            if (nxt == frame_len[req.slot]) begin
              r.frame_last        = 1'b1;
              frame_pos[req.slot] = '0;
              frame_len[req.slot] = lim_min;
            end else begin
              frame_pos[req.slot] = nxt;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic out_t result_of(logic [2:0] s, logic nf, logic [7:0] b, logic [7:0] p,
                                     logic fl, logic mal, logic dr);
    out_t r;
    r.out_slot      = s;
    r.no_free_slot  = nf;
    r.out_byte      = b;
    r.byte_position = p;
    r.frame_last    = fl;
    r.malformed     = mal;
    r.dropped       = dr;
    return r;
  endfunction

  function automatic stim_row_t stim_row(logic [1:0] rt, logic [2:0] s, logic [7:0] b,
                                         logic ce, bit typed, out_t want);
    stim_row_t row;
    row.req.req_type  = rt;
    row.req.slot      = s;
    row.req.data_byte = b;
    row.req.chunk_end = ce;
    row.typed         = typed;
    row.want          = want;
    return row;
  endfunction

  function automatic string fmt_result(out_t r);
    return $sformatf("slot=%0d nofree=%0b byte=%02h pos=%0d last=%0b mal=%0b drop=%0b",
                     r.out_slot, r.no_free_slot, r.out_byte, r.byte_position,
                     r.frame_last, r.malformed, r.dropped);
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic in_t random_request();
    in_t req;
    int  live[$];
    int  r;
    int  hi;
    for (int k = 0; k < USABLE_SLOTS; k++) begin
      if (slot_on[k]) live.push_back(k);
    end
    req.req_type  = REQ_DATA;
    req.slot      = 3'($urandom);
    req.data_byte = 8'($urandom);
    req.chunk_end = ($urandom_range(0, 4) == 0);
    r = $urandom_range(0, 99);
    if (r < 7 || (live.size() == 0 && r < 40)) begin
      req.req_type = REQ_CONNECT;
    end else if (r < 11) begin
      req.req_type = REQ_DISCONNECT;
    end else if (r < 13) begin
      req.req_type = REQ_UNKNOWN;
    end else begin
      if (live.size() != 0 && $urandom_range(0, 9) != 0)
        req.slot = 3'(live[$urandom_range(0, live.size() - 1)]);
      if (req.slot < USABLE_SLOTS && frame_pos[req.slot] == LENGTH_POS &&
          lim_min <= lim_max && $urandom_range(0, 4) != 0) begin
        hi = (int'(lim_max) > int'(lim_min) + 12) ? int'(lim_min) + 12 : int'(lim_max);
        r  = $urandom_range(0, 9);
        if (r == 0) req.data_byte = lim_min;
        else if (r == 1) req.data_byte = lim_max;
        else req.data_byte = 8'($urandom_range(int'(lim_min), hi));
      end
    end
    return req;
  endfunction

  task automatic offer_request(input in_t req, input bit typed, input out_t want);
    out_t predicted;
    int   gap;
    in_valid_i <= 1'b1;
    in_i       <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = predict_deframe(req);
    pending_results.push_back(typed ? want : predicted);
    gap = tx_idle_en ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_limit(input logic idx, input logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    if (idx == CFG_MIN_FRAME_LEN) lim_min = value;
    else lim_max = value;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin : rx_side
    int run;
    forever begin
      run = 0;
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        run         = LONG_HOLD;
      end else if (rx_idle_en) begin
        run = idle_len();
      end
      if (run > 0) begin
        out_stall_i <= 1'b1;
        repeat (run) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10) $display("unexpected result: %s", fmt_result(out_o));
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_o !== want) begin
          if (mismatches < 10)
            $display("result mismatch: exp %s, got %s", fmt_result(want), fmt_result(out_o));
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_multi_slot_length_deframer_top NOT OK");
      $finish;
    end
  end

  initial begin : main_seq
    stim_row_t  rows[$];
    logic [7:0] mins[PHASES];
    logic [7:0] maxs[PHASES];
    int         k;
    int         p;
    int         n;
    for (k = 0; k < 8; k++) begin
      slot_on[k]    = 1'b0;
      frame_pos[k]  = '0;
      frame_len[k]  = MIN_FRAME_LEN_RST;
      skip_chunk[k] = 1'b0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // closed slots, unknown request, first connect
    rows.push_back(stim_row(REQ_DATA, 3'd0, 8'h5A, 1'b0, 1'b1,
                            result_of(3'd0, 1'b0, 8'h5A, 8'd0, 1'b0, 1'b0, 1'b1)));
    rows.push_back(stim_row(REQ_DISCONNECT, 3'd3, 8'hC3, 1'b1, 1'b1,
                            result_of(3'd3, 1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0)));
    rows.push_back(stim_row(REQ_UNKNOWN, 3'd5, 8'hFF, 1'b1, 1'b1,
                            result_of(3'd5, 1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0)));
    rows.push_back(stim_row(REQ_DATA, 3'd7, 8'hFF, 1'b1, 1'b1,
                            result_of(3'd7, 1'b0, 8'hFF, 8'd0, 1'b0, 1'b0, 1'b1)));
    rows.push_back(stim_row(REQ_CONNECT, 3'd6, 8'h00, 1'b0, 1'b1,
                            result_of(3'd0, 1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0)));
    // short length mid-chunk: abort and skip to chunk end
    rows.push_back(stim_row(REQ_DATA, 3'd0, 8'h00, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(REQ_DATA, 3'd0, 8'hFF, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(REQ_DATA, 3'd0, 8'h12, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(REQ_DATA, 3'd0, 8'h34, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(REQ_DATA, 3'd0, 8'h07, 1'b0, 1'b1,
                            result_of(3'd0, 1'b0, 8'h07, 8'd4, 1'b0, 1'b1, 1'b0)));
    rows.push_back(stim_row(REQ_DATA, 3'd0, 8'hAA, 1'b0, 1'b1,
                            result_of(3'd0, 1'b0, 8'hAA, 8'd0, 1'b0, 1'b0, 1'b1)));
    rows.push_back(stim_row(REQ_DATA, 3'd0, 8'h55, 1'b1, 1'b1,
                            result_of(3'd0, 1'b0, 8'h55, 8'd0, 1'b0, 1'b0, 1'b1)));
    // long length on the chunk's last byte: abort without skipping
    rows.push_back(stim_row(REQ_DATA, 3'd0, 8'h01, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(REQ_DATA, 3'd0, 8'h02, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(REQ_DATA, 3'd0, 8'h03, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(REQ_DATA, 3'd0, 8'h04, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(REQ_DATA, 3'd0, 8'd81, 1'b1, 1'b1,
                            result_of(3'd0, 1'b0, 8'd81, 8'd4, 1'b0, 1'b1, 1'b0)));
    // fill every slot, then one connect too many
    for (k = 0; k < USABLE_SLOTS - 1; k++)
      rows.push_back(stim_row(REQ_CONNECT, 3'($urandom), 8'($urandom), 1'b0, 1'b0, '0));
    rows.push_back(stim_row(REQ_CONNECT, 3'd2, 8'h00, 1'b0, 1'b1,
                            result_of(3'd0, 1'b1, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0)));

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (k = 0; k < rows.size(); k++) offer_request(rows[k].req, rows[k].typed, rows[k].want);

    mins = '{8'd8, 8'd5, 8'd255, 8'd20, 8'd0, 8'd0, 8'd5, 8'd0, 8'd0, 8'd6};
    maxs = '{8'd80, 8'd255, 8'd255, 8'd10, 8'd4, 8'd255, 8'd5, 8'd0, 8'd0, 8'd12};
    mins[7] = 8'($urandom_range(5, 60));
    maxs[7] = 8'($urandom_range(int'(mins[7]), 255));
    mins[8] = 8'($urandom_range(5, 255));
    maxs[8] = 8'($urandom_range(5, 255));

    for (p = 0; p < PHASES; p++) begin
      in_valid_i <= 1'b0;
      wait_drained();
      if ($urandom_range(0, 1) == 1) begin
        write_limit(CFG_MIN_FRAME_LEN, mins[p]);
        write_limit(CFG_MAX_FRAME_LEN, maxs[p]);
      end else begin
        write_limit(CFG_MAX_FRAME_LEN, maxs[p]);
        write_limit(CFG_MIN_FRAME_LEN, mins[p]);
      end
      cfg_valid_i <= 1'b0;
      tx_idle_en  = (p % 3 != 0) && (p != 2);
      rx_idle_en  = (p % 3 != 0);
      if (p == 2) rx_hold_req = 1'b1;
      for (n = 0; n < ITEMS_PER_PHASE; n++) offer_request(random_request(), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_multi_slot_length_deframer_top OK");
    end else begin
      $display("tb_multi_slot_length_deframer_top NOT OK");
    end
    $finish;
  end

endmodule
